// ===== hw/rtl/lscf_pkg.sv =====
// shared types, constants and fit microprogram for the least-squares circle fit core
`default_nettype none

package lscf_pkg;

    // fixed field widths
    localparam int PIX_W    = 11;
    localparam int CNT_W    = 23;
    localparam int OUT_W    = 16;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 72;

    // parameter defaults
    localparam int COORD_BITS_DEF = 11;
    localparam int FRAC_BITS_DEF  = 4;

    // point count saturation value
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // wide datapath word and register file
    localparam int WORD_W   = 416;
    localparam int RF_AW    = 5;
    localparam int RF_DEPTH = 32;
    localparam int PC_W     = 7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC1,
        ST_ACC2,
        ST_LOAD,
        ST_FETCH,
        ST_EXEC,
        ST_ITER,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_SHLF,
        OP_SHLQ,
        OP_FDIV,
        OP_UDIV,
        OP_SQRT,
        OP_BRPOS,
        OP_CHKPOS,
        OP_SATX,
        OP_SATY,
        OP_SATR,
        OP_DONE
    } op_t;

    typedef logic [RF_AW-1:0] raddr_t;

    // moment registers, loaded in this order
    localparam raddr_t R_N    = 5'd0;
    localparam raddr_t R_SX   = 5'd1;
    localparam raddr_t R_SY   = 5'd2;
    localparam raddr_t R_SXX  = 5'd3;
    localparam raddr_t R_SYY  = 5'd4;
    localparam raddr_t R_SXY  = 5'd5;
    localparam raddr_t R_SXXX = 5'd6;
    localparam raddr_t R_SYYY = 5'd7;
    localparam raddr_t R_SXYY = 5'd8;
    localparam raddr_t R_SYXX = 5'd9;
    // working registers
    localparam raddr_t R_CUU  = 5'd10;
    localparam raddr_t R_CVV  = 5'd11;
    localparam raddr_t R_CUV  = 5'd12;
    localparam raddr_t R_N2   = 5'd13;
    localparam raddr_t R_Q    = 5'd14;
    localparam raddr_t R_T    = 5'd15;
    localparam raddr_t R_U    = 5'd16;
    localparam raddr_t R_D1   = 5'd17;
    localparam raddr_t R_D2   = 5'd18;
    localparam raddr_t R_DET  = 5'd19;
    localparam raddr_t R_NU   = 5'd20;
    localparam raddr_t R_NV   = 5'd21;
    localparam raddr_t R_DEN  = 5'd22;
    localparam raddr_t R_NX   = 5'd23;
    localparam raddr_t R_NY   = 5'd24;
    localparam raddr_t R_DD   = 5'd25;

    typedef struct packed {
        op_t    op;
        raddr_t dst;
        raddr_t a;
        raddr_t b;
    } instr_t;

    // fit microprogram: centred moments, 2x2 solve, rounding and square root
    function automatic instr_t prog_rom(input logic [PC_W-1:0] pc);
        instr_t r;
        case (pc)
            // n^2 times centred second moments
            7'd0:  r = '{OP_MUL, R_CUU, R_N, R_SXX};
            7'd1:  r = '{OP_MUL, R_T, R_SX, R_SX};
            7'd2:  r = '{OP_SUB, R_CUU, R_CUU, R_T};
            7'd3:  r = '{OP_MUL, R_CVV, R_N, R_SYY};
            7'd4:  r = '{OP_MUL, R_T, R_SY, R_SY};
            7'd5:  r = '{OP_SUB, R_CVV, R_CVV, R_T};
            7'd6:  r = '{OP_MUL, R_CUV, R_N, R_SXY};
            7'd7:  r = '{OP_MUL, R_T, R_SX, R_SY};
            7'd8:  r = '{OP_SUB, R_CUV, R_CUV, R_T};
            7'd9:  r = '{OP_MUL, R_N2, R_N, R_N};
            7'd10: r = '{OP_MUL, R_Q, R_SX, R_SX};
            7'd11: r = '{OP_MUL, R_T, R_SY, R_SY};
            7'd12: r = '{OP_ADD, R_Q, R_Q, R_T};
            // first right-hand side
            7'd13: r = '{OP_ADD, R_D1, R_SXXX, R_SXYY};
            7'd14: r = '{OP_MUL, R_D1, R_N2, R_D1};
            7'd15: r = '{OP_MUL, R_T, R_SX, R_SXX};
            7'd16: r = '{OP_ADD, R_U, R_T, R_T};
            7'd17: r = '{OP_ADD, R_T, R_U, R_T};
            7'd18: r = '{OP_MUL, R_U, R_SY, R_SXY};
            7'd19: r = '{OP_ADD, R_U, R_U, R_U};
            7'd20: r = '{OP_ADD, R_T, R_T, R_U};
            7'd21: r = '{OP_MUL, R_U, R_SX, R_SYY};
            7'd22: r = '{OP_ADD, R_T, R_T, R_U};
            7'd23: r = '{OP_MUL, R_T, R_N, R_T};
            7'd24: r = '{OP_SUB, R_D1, R_D1, R_T};
            7'd25: r = '{OP_MUL, R_T, R_SX, R_Q};
            7'd26: r = '{OP_ADD, R_T, R_T, R_T};
            7'd27: r = '{OP_ADD, R_D1, R_D1, R_T};
            // second right-hand side
            7'd28: r = '{OP_ADD, R_D2, R_SYYY, R_SYXX};
            7'd29: r = '{OP_MUL, R_D2, R_N2, R_D2};
            7'd30: r = '{OP_MUL, R_T, R_SY, R_SYY};
            7'd31: r = '{OP_ADD, R_U, R_T, R_T};
            7'd32: r = '{OP_ADD, R_T, R_U, R_T};
            7'd33: r = '{OP_MUL, R_U, R_SX, R_SXY};
            7'd34: r = '{OP_ADD, R_U, R_U, R_U};
            7'd35: r = '{OP_ADD, R_T, R_T, R_U};
            7'd36: r = '{OP_MUL, R_U, R_SY, R_SXX};
            7'd37: r = '{OP_ADD, R_T, R_T, R_U};
            7'd38: r = '{OP_MUL, R_T, R_N, R_T};
            7'd39: r = '{OP_SUB, R_D2, R_D2, R_T};
            7'd40: r = '{OP_MUL, R_T, R_SY, R_Q};
            7'd41: r = '{OP_ADD, R_T, R_T, R_T};
            7'd42: r = '{OP_ADD, R_D2, R_D2, R_T};
            // determinant, abort when not positive
            7'd43: r = '{OP_MUL, R_DET, R_CUU, R_CVV};
            7'd44: r = '{OP_MUL, R_T, R_CUV, R_CUV};
            7'd45: r = '{OP_SUB, R_DET, R_DET, R_T};
            7'd46: r = '{OP_BRPOS, R_DET, R_DET, R_DET};
            // solve
            7'd47: r = '{OP_MUL, R_NU, R_CVV, R_D1};
            7'd48: r = '{OP_MUL, R_T, R_CUV, R_D2};
            7'd49: r = '{OP_SUB, R_NU, R_NU, R_T};
            7'd50: r = '{OP_MUL, R_NV, R_CUU, R_D2};
            7'd51: r = '{OP_MUL, R_T, R_CUV, R_D1};
            7'd52: r = '{OP_SUB, R_NV, R_NV, R_T};
            7'd53: r = '{OP_MUL, R_DEN, R_N, R_DET};
            7'd54: r = '{OP_ADD, R_DEN, R_DEN, R_DEN};
            7'd55: r = '{OP_MUL, R_NX, R_SX, R_DET};
            7'd56: r = '{OP_ADD, R_NX, R_NX, R_NX};
            7'd57: r = '{OP_ADD, R_NX, R_NX, R_NU};
            7'd58: r = '{OP_MUL, R_NY, R_SY, R_DET};
            7'd59: r = '{OP_ADD, R_NY, R_NY, R_NY};
            7'd60: r = '{OP_ADD, R_NY, R_NY, R_NV};
            // scaled radius squared
            7'd61: r = '{OP_MUL, R_Q, R_NU, R_NU};
            7'd62: r = '{OP_MUL, R_T, R_NV, R_NV};
            7'd63: r = '{OP_ADD, R_Q, R_Q, R_T};
            7'd64: r = '{OP_MUL, R_T, R_DET, R_DET};
            7'd65: r = '{OP_ADD, R_T, R_T, R_T};
            7'd66: r = '{OP_ADD, R_T, R_T, R_T};
            7'd67: r = '{OP_ADD, R_U, R_CUU, R_CVV};
            7'd68: r = '{OP_MUL, R_T, R_T, R_U};
            7'd69: r = '{OP_ADD, R_Q, R_Q, R_T};
            // validity
            7'd70: r = '{OP_CHKPOS, R_NX, R_NX, R_NX};
            7'd71: r = '{OP_CHKPOS, R_NY, R_NY, R_NY};
            7'd72: r = '{OP_CHKPOS, R_Q, R_Q, R_Q};
            // rounded centre
            7'd73: r = '{OP_ADD, R_DD, R_DEN, R_DEN};
            7'd74: r = '{OP_SHLF, R_T, R_NX, R_NX};
            7'd75: r = '{OP_ADD, R_T, R_T, R_DEN};
            7'd76: r = '{OP_FDIV, R_T, R_T, R_DD};
            7'd77: r = '{OP_SATX, R_T, R_T, R_T};
            7'd78: r = '{OP_SHLF, R_T, R_NY, R_NY};
            7'd79: r = '{OP_ADD, R_T, R_T, R_DEN};
            7'd80: r = '{OP_FDIV, R_T, R_T, R_DD};
            7'd81: r = '{OP_SATY, R_T, R_T, R_T};
            // rounded radius
            7'd82: r = '{OP_SHLQ, R_T, R_Q, R_Q};
            7'd83: r = '{OP_SQRT, R_T, R_T, R_T};
            7'd84: r = '{OP_ADD, R_T, R_T, R_DEN};
            7'd85: r = '{OP_UDIV, R_T, R_T, R_DD};
            7'd86: r = '{OP_SATR, R_T, R_T, R_T};
            default: r = '{OP_DONE, R_T, R_T, R_T};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/least_squares_circle_fit_core.sv =====
// least-squares circle fit core: moment accumulation and microcoded wide-word solver
//
// Input channel s_*: one pixel per item (column, row, mask bit); s_tlast marks the
// last pixel of a frame. Each pixel passes through capture, square products, then cube
// products and moment update; s_tready is low during the product steps.
// On the last pixel the moments are copied into a wide register file
// and a microprogram of 87 steps runs on one shared wide adder and shift unit:
// each step passes through fetch and execute, and multiply, divide and square root
// steps then iterate. A multiply runs one cycle per multiplier bit up to the
// highest set bit (at most WORD_W), a division and the square root iterate over
// their quotient and result bits; the multiply iterations dominate a frame end.
// Output channel m_*: one result item per frame. The result sits in an output
// register, so the next frame's pixels are taken while it waits; only the end of
// a following fit waits for the receiver to take it.
// Reset (aresetn low, synchronous) clears the moments, the control state and the
// output valid. All moments return to zero after each frame.
`default_nettype none

module least_squares_circle_fit_core #(
    parameter int COORD_BITS = lscf_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = lscf_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // pixel_x[10:0], pixel_y[21:11], pixel_set[22], zero[23]
    input  wire logic [lscf_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // center_x[15:0], center_y[31:16], radius[47:32], fit_valid[48], point_count[71:49]
    output logic [lscf_pkg::M_DATA_W-1:0]      m_tdata
);

    localparam int W     = lscf_pkg::WORD_W;
    localparam int CB    = COORD_BITS;
    localparam int CW    = lscf_pkg::CNT_W;
    localparam int OW    = lscf_pkg::OUT_W;
    localparam int P2    = 2 * CB;
    localparam int P3    = 3 * CB;
    localparam int S1_W  = CB + CW;
    localparam int S2_W  = 2 * CB + CW;
    localparam int S3_W  = 3 * CB + CW;
    localparam int SHF   = FRAC_BITS + 1;
    localparam int SHQ   = 2 * FRAC_BITS + 2;
    localparam int IT_W  = $clog2(W + 1);
    localparam int PX_W  = lscf_pkg::PIX_W;

    lscf_pkg::state_t state_reg, state_next;

    // captured pixel and products
    logic [CB-1:0]  x_reg, y_reg;
    logic           set_reg, last_reg;
    logic [P2-1:0]  xx_reg, yy_reg, xy_reg;

    // moments
    logic [CW-1:0]   count_reg;
    logic [S1_W-1:0] sx_reg, sy_reg;
    logic [S2_W-1:0] sxx_reg, syy_reg, sxy_reg;
    logic [S3_W-1:0] sxxx_reg, syyy_reg, sxyy_reg, syxx_reg;

    // sequencer
    logic [3:0]                    ld_reg;
    logic [lscf_pkg::PC_W-1:0]     pc_reg;
    lscf_pkg::instr_t              instr;

    // register file
    logic [W-1:0]                  rf [lscf_pkg::RF_DEPTH];
    logic [W-1:0]                  rda_reg, rdb_reg;
    logic                          wr_en;
    lscf_pkg::raddr_t              wr_addr;
    logic [W-1:0]                  wr_data;

    // shared unit
    logic [W-1:0]   ua_reg, ub_reg;
    logic [W:0]     up_reg;
    logic [IT_W-1:0] cnt_reg;
    logic           neg_reg;
    logic [W:0]     add_x, add_y;
    logic           add_ci;
    logic [W+1:0]   add_sum;
    logic           add_ge;
    logic           fin;
    logic [W:0]     div_rs;

    // fit results and output register
    logic [OW-1:0]  cx_reg, cy_reg, rad_reg;
    logic           fv_reg;
    logic [CW-1:0]  pcnt_reg;
    logic           m_valid_reg;
    logic [lscf_pkg::M_DATA_W-1:0] m_data_reg;
    logic           out_load;

    // input fields
    logic [PX_W:0]  pix_x_ext, pix_y_ext;
    logic [CB-1:0]  x_in, y_in;

    // operand checks
    logic           a_pos;
    logic [OW-1:0]  sat_s, sat_u;
    logic           s_over, s_under;
    logic [W-1:0]   moment;

    assign pix_x_ext = {1'b0, s_tdata[PX_W-1:0]};
    assign pix_y_ext = {1'b0, s_tdata[2*PX_W-1:PX_W]};
    assign x_in      = pix_x_ext[CB-1:0];
    assign y_in      = pix_y_ext[CB-1:0];

    assign s_tready = (state_reg == lscf_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign instr = lscf_pkg::prog_rom(pc_reg);

    // shared adder, also used as comparator through its carry
    assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{(W+1){1'b0}}, add_ci};
    assign add_ge  = add_sum[W+1];
    assign div_rs  = {up_reg[W-1:0], ua_reg[W-1]};
    assign fin     = (instr.op == lscf_pkg::OP_MUL) ? (ub_reg == '0) : (cnt_reg == '0);

    // sign tests and saturation of operand a
    assign a_pos   = !rda_reg[W-1] && (|rda_reg);
    assign s_over  = !rda_reg[W-1] && (|rda_reg[W-2:OW-1]);
    assign s_under = rda_reg[W-1] && !(&rda_reg[W-2:OW-1]);
    always_comb begin
        if (s_over) begin
            sat_s = {1'b0, {(OW-1){1'b1}}};
        end else if (s_under) begin
            sat_s = {1'b1, {(OW-1){1'b0}}};
        end else begin
            sat_s = rda_reg[OW-1:0];
        end
        sat_u = (|rda_reg[W-1:OW]) ? {OW{1'b1}} : rda_reg[OW-1:0];
    end

    assign out_load = (state_reg == lscf_pkg::ST_OUT) && (!m_valid_reg || m_tready);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lscf_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = lscf_pkg::ST_ACC1;
            end
            lscf_pkg::ST_ACC1: state_next = lscf_pkg::ST_ACC2;
            lscf_pkg::ST_ACC2: begin
                state_next = last_reg ? lscf_pkg::ST_LOAD : lscf_pkg::ST_IDLE;
            end
            lscf_pkg::ST_LOAD: begin
                if (ld_reg == 4'(lscf_pkg::R_SYXX)) begin
                    state_next = (count_reg == '0) ? lscf_pkg::ST_OUT : lscf_pkg::ST_FETCH;
                end
            end
            lscf_pkg::ST_FETCH: state_next = lscf_pkg::ST_EXEC;
            lscf_pkg::ST_EXEC: begin
                case (instr.op)
                    lscf_pkg::OP_MUL, lscf_pkg::OP_FDIV,
                    lscf_pkg::OP_UDIV, lscf_pkg::OP_SQRT: state_next = lscf_pkg::ST_ITER;
                    lscf_pkg::OP_BRPOS: begin
                        state_next = a_pos ? lscf_pkg::ST_FETCH : lscf_pkg::ST_OUT;
                    end
                    lscf_pkg::OP_DONE: state_next = lscf_pkg::ST_OUT;
                    default:           state_next = lscf_pkg::ST_FETCH;
                endcase
            end
            lscf_pkg::ST_ITER: begin
                if (fin) state_next = lscf_pkg::ST_FETCH;
            end
            lscf_pkg::ST_OUT: begin
                if (out_load) state_next = lscf_pkg::ST_IDLE;
            end
            default: state_next = lscf_pkg::ST_IDLE;
        endcase
    end

    // adder operand selection
    always_comb begin
        add_x  = '0;
        add_y  = '0;
        add_ci = 1'b0;
        case (state_reg)
            lscf_pkg::ST_EXEC: begin
                case (instr.op)
                    lscf_pkg::OP_ADD: begin
                        add_x = {1'b0, rda_reg};
                        add_y = {1'b0, rdb_reg};
                    end
                    lscf_pkg::OP_SUB: begin
                        add_x  = {1'b0, rda_reg};
                        add_y  = ~{1'b0, rdb_reg};
                        add_ci = 1'b1;
                    end
                    // floor division of a negative numerator: den - num - 1
                    lscf_pkg::OP_FDIV: begin
                        add_x = {1'b0, rdb_reg};
                        add_y = {1'b0, ~rda_reg};
                    end
                    default: ;
                endcase
            end
            lscf_pkg::ST_ITER: begin
                if (fin) begin
                    add_y  = ~{1'b0, ua_reg};
                    add_ci = 1'b1;
                end else begin
                    case (instr.op)
                        lscf_pkg::OP_MUL: begin
                            add_x = {1'b0, up_reg[W-1:0]};
                            add_y = {1'b0, ua_reg};
                        end
                        lscf_pkg::OP_FDIV, lscf_pkg::OP_UDIV: begin
                            add_x  = div_rs;
                            add_y  = ~{1'b0, ub_reg};
                            add_ci = 1'b1;
                        end
                        lscf_pkg::OP_SQRT: begin
                            add_x  = up_reg;
                            add_y  = ~{1'b0, ua_reg | ub_reg};
                            add_ci = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // moment selected for loading
    always_comb begin
        case ({1'b0, ld_reg})
            lscf_pkg::R_N:    moment = {{(W-CW){1'b0}}, count_reg};
            lscf_pkg::R_SX:   moment = {{(W-S1_W){1'b0}}, sx_reg};
            lscf_pkg::R_SY:   moment = {{(W-S1_W){1'b0}}, sy_reg};
            lscf_pkg::R_SXX:  moment = {{(W-S2_W){1'b0}}, sxx_reg};
            lscf_pkg::R_SYY:  moment = {{(W-S2_W){1'b0}}, syy_reg};
            lscf_pkg::R_SXY:  moment = {{(W-S2_W){1'b0}}, sxy_reg};
            lscf_pkg::R_SXXX: moment = {{(W-S3_W){1'b0}}, sxxx_reg};
            lscf_pkg::R_SYYY: moment = {{(W-S3_W){1'b0}}, syyy_reg};
            lscf_pkg::R_SXYY: moment = {{(W-S3_W){1'b0}}, sxyy_reg};
            lscf_pkg::R_SYXX: moment = {{(W-S3_W){1'b0}}, syxx_reg};
            default:          moment = '0;
        endcase
    end

    // register file write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = instr.dst;
        wr_data = add_sum[W-1:0];
        case (state_reg)
            lscf_pkg::ST_LOAD: begin
                wr_en   = 1'b1;
                wr_addr = {1'b0, ld_reg};
                wr_data = moment;
            end
            lscf_pkg::ST_EXEC: begin
                case (instr.op)
                    lscf_pkg::OP_ADD, lscf_pkg::OP_SUB: wr_en = 1'b1;
                    lscf_pkg::OP_SHLF: begin
                        wr_en   = 1'b1;
                        wr_data = rda_reg << SHF;
                    end
                    lscf_pkg::OP_SHLQ: begin
                        wr_en   = 1'b1;
                        wr_data = rda_reg << SHQ;
                    end
                    default: ;
                endcase
            end
            lscf_pkg::ST_ITER: begin
                if (fin) begin
                    wr_en = 1'b1;
                    if (instr.op == lscf_pkg::OP_MUL) begin
                        wr_data = up_reg[W-1:0];
                    end else if (instr.op == lscf_pkg::OP_FDIV && neg_reg) begin
                        wr_data = add_sum[W-1:0];
                    end else begin
                        wr_data = ua_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    // register file storage
    always_ff @(posedge aclk) begin
        if (wr_en) rf[wr_addr] <= wr_data;
        rda_reg <= rf[instr.a];
        rdb_reg <= rf[instr.b];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lscf_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // moment accumulation, cleared after each frame is loaded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxx_reg   <= '0;
            syy_reg   <= '0;
            sxy_reg   <= '0;
            sxxx_reg  <= '0;
            syyy_reg  <= '0;
            sxyy_reg  <= '0;
            syxx_reg  <= '0;
        end else if (state_reg == lscf_pkg::ST_ACC2 && set_reg && count_reg != lscf_pkg::CNT_MAX) begin
            count_reg <= count_reg + 1'b1;
            sx_reg    <= sx_reg + S1_W'(x_reg);
            sy_reg    <= sy_reg + S1_W'(y_reg);
            sxx_reg   <= sxx_reg + S2_W'(xx_reg);
            syy_reg   <= syy_reg + S2_W'(yy_reg);
            sxy_reg   <= sxy_reg + S2_W'(xy_reg);
            sxxx_reg  <= sxxx_reg + S3_W'(P3'(xx_reg) * P3'(x_reg));
            syyy_reg  <= syyy_reg + S3_W'(P3'(yy_reg) * P3'(y_reg));
            sxyy_reg  <= sxyy_reg + S3_W'(P3'(yy_reg) * P3'(x_reg));
            syxx_reg  <= syxx_reg + S3_W'(P3'(xx_reg) * P3'(y_reg));
        end else if (state_reg == lscf_pkg::ST_LOAD && ld_reg == 4'(lscf_pkg::R_SYXX)) begin
            count_reg <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxx_reg   <= '0;
            syy_reg   <= '0;
            sxy_reg   <= '0;
            sxxx_reg  <= '0;
            syyy_reg  <= '0;
            sxyy_reg  <= '0;
            syxx_reg  <= '0;
        end
    end

    // pixel capture and products
    always_ff @(posedge aclk) begin
        if (state_reg == lscf_pkg::ST_IDLE && s_tvalid) begin
            x_reg    <= x_in;
            y_reg    <= y_in;
            set_reg  <= s_tdata[2*PX_W];
            last_reg <= s_tlast;
        end
        if (state_reg == lscf_pkg::ST_ACC1) begin
            xx_reg <= P2'(x_reg) * P2'(x_reg);
            yy_reg <= P2'(y_reg) * P2'(y_reg);
            xy_reg <= P2'(x_reg) * P2'(y_reg);
        end
    end

    // sequencer, shared unit and fit results
    always_ff @(posedge aclk) begin
        case (state_reg)
            lscf_pkg::ST_ACC2: begin
                ld_reg <= '0;
            end
            lscf_pkg::ST_LOAD: begin
                ld_reg <= ld_reg + 1'b1;
                pc_reg <= '0;
                if (ld_reg == '0) begin
                    pcnt_reg <= count_reg;
                    cx_reg   <= '0;
                    cy_reg   <= '0;
                    rad_reg  <= '0;
                    fv_reg   <= 1'b1;
                end
                if (ld_reg == 4'(lscf_pkg::R_SYXX) && count_reg == '0) fv_reg <= 1'b0;
            end
            lscf_pkg::ST_EXEC: begin
                // iterative ops advance the program counter when they finish
                if (instr.op != lscf_pkg::OP_MUL && instr.op != lscf_pkg::OP_FDIV &&
                    instr.op != lscf_pkg::OP_UDIV && instr.op != lscf_pkg::OP_SQRT) begin
                    pc_reg <= pc_reg + 1'b1;
                end
                case (instr.op)
                    lscf_pkg::OP_MUL: begin
                        ua_reg <= rda_reg;
                        ub_reg <= rdb_reg;
                        up_reg <= '0;
                    end
                    lscf_pkg::OP_FDIV: begin
                        ua_reg  <= rda_reg[W-1] ? add_sum[W-1:0] : rda_reg;
                        neg_reg <= rda_reg[W-1];
                        ub_reg  <= rdb_reg;
                        up_reg  <= '0;
                        cnt_reg <= IT_W'(W);
                    end
                    lscf_pkg::OP_UDIV: begin
                        ua_reg  <= rda_reg;
                        neg_reg <= 1'b0;
                        ub_reg  <= rdb_reg;
                        up_reg  <= '0;
                        cnt_reg <= IT_W'(W);
                    end
                    lscf_pkg::OP_SQRT: begin
                        up_reg  <= {1'b0, rda_reg};
                        ua_reg  <= '0;
                        ub_reg  <= {2'b01, {(W-2){1'b0}}};
                        cnt_reg <= IT_W'(W / 2);
                    end
                    lscf_pkg::OP_BRPOS: begin
                        if (!a_pos) fv_reg <= 1'b0;
                    end
                    lscf_pkg::OP_CHKPOS: fv_reg <= fv_reg & a_pos;
                    lscf_pkg::OP_SATX:   cx_reg <= sat_s;
                    lscf_pkg::OP_SATY:   cy_reg <= sat_s;
                    lscf_pkg::OP_SATR:   rad_reg <= sat_u;
                    default: ;
                endcase
            end
            lscf_pkg::ST_ITER: begin
                if (fin) begin
                    pc_reg <= pc_reg + 1'b1;
                end else begin
                    case (instr.op)
                        // shift-add multiply, one multiplier bit per cycle
                        lscf_pkg::OP_MUL: begin
                            if (ub_reg[0]) up_reg <= {1'b0, add_sum[W-1:0]};
                            ua_reg <= ua_reg << 1;
                            ub_reg <= ub_reg >> 1;
                        end
                        // restoring division, one quotient bit per cycle
                        lscf_pkg::OP_FDIV, lscf_pkg::OP_UDIV: begin
                            up_reg  <= add_ge ? add_sum[W:0] : div_rs;
                            ua_reg  <= {ua_reg[W-2:0], add_ge};
                            cnt_reg <= cnt_reg - 1'b1;
                        end
                        // digit-by-digit square root, one result bit per cycle
                        lscf_pkg::OP_SQRT: begin
                            if (add_ge) begin
                                up_reg <= add_sum[W:0];
                                ua_reg <= (ua_reg >> 1) | ub_reg;
                            end else begin
                                ua_reg <= ua_reg >> 1;
                            end
                            ub_reg  <= ub_reg >> 2;
                            cnt_reg <= cnt_reg - 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {pcnt_reg, fv_reg, rad_reg, cy_reg, cx_reg};
        end
    end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// testbench for the least-squares circle fit core: directed and random frames
`timescale 1ns / 100ps

module tb_top;

    typedef logic signed [1023:0] wide_t;

    typedef struct {
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic [15:0]        radius;
        logic               fit_valid;
        logic [22:0]        point_count;
    } circle_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [lscf_pkg::S_DATA_W-1:0] s_tdata = '0;
    logic                          s_tlast = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [lscf_pkg::M_DATA_W-1:0] m_tdata;

    // running moments of the frame in progress
    wide_t mom_n, mom_x, mom_y, mom_xx, mom_yy, mom_xy, mom_xxx, mom_yyy, mom_xyy, mom_yxx;

    circle_t expected_fits[$];
    int      mismatches = 0;
    int      pixels_sent = 0;
    int      fits_seen = 0;
    int      valid_fits = 0;
    bit      no_idle = 1'b0;

    least_squares_circle_fit_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    // floor(num / den), den positive
    function automatic wide_t floor_div(wide_t num, wide_t den);
        if (num >= 0) begin
            return num / den;
        end
        return -((-num + den - 1) / den);
    endfunction

    function automatic wide_t int_sqrt(wide_t a);
        wide_t res;
        wide_t t;
        res = 0;
        for (int b = 255; b >= 0; b--) begin
            t = res | (wide_t'(1) << b);
            if (t * t <= a) res = t;
        end
        return res;
    endfunction

    // rounded to Q.4, ties up, saturated to signed 16 bits
    function automatic logic signed [15:0] round_q4(wide_t num, wide_t den);
        wide_t t;
        t = floor_div((num <<< 5) + den, den <<< 1);
        if (t > 32767) return 16'sh7fff;
        if (t < -32768) return 16'sh8000;
        return t[15:0];
    endfunction

    function automatic circle_t solve_circle();
        circle_t r;
        wide_t cuu, cvv, cuv, n2, sq, d1, d2, det, nu, nv, den, nx, ny, rr, t;
        r = '{0, 0, 0, 1'b0, mom_n[22:0]};
        if (mom_n == 0) return r;
        cuu = mom_n * mom_xx - mom_x * mom_x;
        cvv = mom_n * mom_yy - mom_y * mom_y;
        cuv = mom_n * mom_xy - mom_x * mom_y;
        n2  = mom_n * mom_n;
        sq  = mom_x * mom_x + mom_y * mom_y;
        d1  = n2 * (mom_xxx + mom_xyy)
            - mom_n * (3 * mom_x * mom_xx + 2 * mom_y * mom_xy + mom_x * mom_yy)
            + 2 * mom_x * sq;
        d2  = n2 * (mom_yyy + mom_yxx)
            - mom_n * (3 * mom_y * mom_yy + 2 * mom_x * mom_xy + mom_y * mom_xx)
            + 2 * mom_y * sq;
        det = cuu * cvv - cuv * cuv;
        if (det <= 0) return r;
        nu  = cvv * d1 - cuv * d2;
        nv  = cuu * d2 - cuv * d1;
        den = 2 * mom_n * det;
        nx  = 2 * mom_x * det + nu;
        ny  = 2 * mom_y * det + nv;
        rr  = nu * nu + nv * nv + 4 * det * det * (cuu + cvv);
        r.center_x = round_q4(nx, den);
        r.center_y = round_q4(ny, den);
        t = (int_sqrt(rr <<< 10) + den) / (den <<< 1);
        r.radius = (t > 65535) ? 16'hffff : t[15:0];
        r.fit_valid = (nx > 0) && (ny > 0) && (rr > 0);
        return r;
    endfunction

    function automatic void clear_moments();
        mom_n = 0; mom_x = 0; mom_y = 0; mom_xx = 0; mom_yy = 0; mom_xy = 0;
        mom_xxx = 0; mom_yyy = 0; mom_xyy = 0; mom_yxx = 0;
    endfunction

    // update the moments for one accepted pixel
    function automatic void take_pixel(logic [10:0] px, logic [10:0] py, logic set, logic last);
        wide_t x, y;
        x = wide_t'(px);
        y = wide_t'(py);
        if (set && mom_n < 8388607) begin
            mom_n = mom_n + 1;
            mom_x = mom_x + x; mom_y = mom_y + y;
            mom_xx = mom_xx + x * x; mom_yy = mom_yy + y * y; mom_xy = mom_xy + x * y;
            mom_xxx = mom_xxx + x * x * x; mom_yyy = mom_yyy + y * y * y;
            mom_xyy = mom_xyy + x * y * y; mom_yxx = mom_yxx + y * x * x;
        end
        if (last) begin
            expected_fits.insert(expected_fits.size(), solve_circle());
            clear_moments();
        end
    endfunction

    // send one pixel item; valid stays high after acceptance
    task automatic send_pixel(input int px, input int py, input bit set, input bit last);
        int gap;
        if (!no_idle && $urandom_range(99) < 13) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, set, py[10:0], px[10:0]};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        take_pixel(px[10:0], py[10:0], set, last);
        pixels_sent++;
    endtask

    task automatic send_frame3(input int x0, y0, x1, y1, x2, y2);
        send_pixel(x0, y0, 1, 0);
        send_pixel(x1, y1, 1, 0);
        send_pixel(x2, y2, 1, 1);
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("mismatch on fit %0d: %s got %0d expected %0d", fits_seen, what, got, want);
        mismatches++;
    endtask

    // receiver stalls
    always @(posedge aclk) begin
        m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 13);
    end

    // compare each result item with the oldest expected fit
    always @(posedge aclk) begin
        circle_t want;
        if (aresetn && m_tvalid && m_tready) begin
            fits_seen++;
            if (expected_fits.size() == 0) begin
                report("unexpected result item", 1, 0);
            end else begin
                want = expected_fits.pop_front();
                if (want.fit_valid) valid_fits++;
                if (m_tdata[15:0] != want.center_x)
                    report("center_x", $signed(m_tdata[15:0]), want.center_x);
                if (m_tdata[31:16] != want.center_y)
                    report("center_y", $signed(m_tdata[31:16]), want.center_y);
                if (m_tdata[47:32] != want.radius)
                    report("radius", m_tdata[47:32], want.radius);
                if (m_tdata[48] != want.fit_valid)
                    report("fit_valid", m_tdata[48], want.fit_valid);
                if (m_tdata[71:49] != want.point_count)
                    report("point_count", m_tdata[71:49], want.point_count);
            end
        end
    end

    // empty frames, one and two points, unset last pixel
    task automatic test_degenerate();
        send_pixel(5, 5, 0, 0);
        send_pixel(2047, 2047, 0, 1);
        send_pixel(100, 200, 1, 1);
        send_pixel(10, 10, 1, 0);
        send_pixel(20, 30, 1, 0);
        send_pixel(0, 0, 0, 1);
    endtask

    // collinear points give a singular system
    task automatic test_collinear();
        send_frame3(0, 0, 1024, 1024, 2047, 2047);
    endtask

    // well-formed circles, field extremes and corners
    task automatic test_circles();
        send_frame3(100, 50, 150, 100, 100, 150);
        send_frame3(0, 2047, 2047, 0, 2047, 2047);
        send_pixel(0, 0, 1, 0);
        send_pixel(2047, 0, 1, 0);
        send_pixel(0, 2047, 1, 0);
        send_pixel(1365, 682, 0, 0);
        send_pixel(2047, 2047, 1, 1);
    endtask

    // negative centre and saturated outputs
    task automatic test_out_of_range();
        send_frame3(2, 0, 0, 10, 2, 20);
        send_frame3(0, 0, 1000, 1, 2000, 0);
    endtask

    // random frames: mostly noisy circles, some scatter and unset pixels
    task automatic test_random(input int n_items);
        int  sent, len, kind, cx, cy, rad, dx, dy, px, py;
        bit  set;
        sent = 0;
        while (sent < n_items) begin
            len  = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(3, 30);
            kind = $urandom_range(99);
            cx   = $urandom_range(2047);
            cy   = $urandom_range(2047);
            rad  = $urandom_range(2, 900);
            no_idle = (sent > n_items / 2) && (sent < n_items / 2 + 150);
            for (int i = 0; i < len; i++) begin
                if (kind < 60) begin
                    dx = $urandom_range(2 * rad) - rad;
                    dy = $rtoi($sqrt(real'(rad * rad - dx * dx))) + $urandom_range(2) - 1;
                    if ($urandom_range(1)) dy = -dy;
                    px = cx + dx; py = cy + dy;
                    px = px < 0 ? 0 : (px > 2047 ? 2047 : px);
                    py = py < 0 ? 0 : (py > 2047 ? 2047 : py);
                end else begin
                    px = $urandom_range(2047);
                    py = $urandom_range(2047);
                end
                set = (kind < 85) ? ($urandom_range(19) != 0) : $urandom_range(1);
                send_pixel(px, py, set, i == len - 1);
                sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        clear_moments();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_degenerate();
        test_collinear();
        test_circles();
        test_out_of_range();
        test_random(1230);
        s_tvalid <= 1'b0;
        while (expected_fits.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("sent %0d pixels, checked %0d fits (%0d valid), %0d mismatches",
                 pixels_sent, fits_seen, valid_fits, mismatches);
        if (mismatches == 0 && expected_fits.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // run limit
    initial begin
        #1000ms;
        $display("timeout with %0d fits outstanding", expected_fits.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/lscf_pkg.sv
hw/rtl/least_squares_circle_fit_core.sv
test/tb_top.sv
